// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of the channel frame demux buffer.
// No dependencies; each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled at the rising clock edge, off during reset.
`define CFDB_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cfdb: assertion failed");

// Next-cycle implication, sampled at the rising clock edge, off during reset.
`define CFDB_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cfdb: assertion failed");

`endif

// File: hw/rtl/cfdb_pkg.sv
// Package of the channel frame demux buffer: sizes, codes and the result record.
// No dependencies; the RTL takes its names by scope, the testbench imports them.
package cfdb_pkg;

    localparam int STORE_DEPTH = 256;
    localparam int CHANNELS    = 3;
    localparam int BYTE_W      = 8;
    localparam int CH_W        = 2;
    localparam int HEAD_W      = $clog2(STORE_DEPTH);
    localparam int FILL_W      = $clog2(STORE_DEPTH + 1);
    localparam int SUM_W       = FILL_W + 1;
    localparam int MEM_DEPTH   = CHANNELS * STORE_DEPTH;
    localparam int ADDR_W      = $clog2(MEM_DEPTH);
    localparam int CFG_IDX_W   = 2;

    typedef enum logic [0:0] {
        OP_RX  = 1'b0,
        OP_POP = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_SKIP    = 3'd0,
        ST_OPEN    = 3'd1,
        ST_STORED  = 3'd2,
        ST_DISCARD = 3'd3,
        ST_CLOSE   = 3'd4,
        ST_POPPED  = 3'd5,
        ST_EMPTY   = 3'd6
    } status_t;

    typedef enum logic [CH_W-1:0] {
        CH_AT    = 2'd0,
        CH_DEBUG = 2'd1,
        CH_SETUP = 2'd2,
        CH_NONE  = 2'd3
    } chan_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELIM = 2'd0,
        CFG_AT    = 2'd1,
        CFG_DEBUG = 2'd2,
        CFG_SETUP = 2'd3
    } cfg_idx_t;

    localparam logic [BYTE_W-1:0] DELIM_RESET = 8'h02;
    localparam logic [BYTE_W-1:0] AT_RESET    = 8'h16;
    localparam logic [BYTE_W-1:0] DEBUG_RESET = 8'h12;
    localparam logic [BYTE_W-1:0] SETUP_RESET = 8'h19;

    // One result record as it travels down the output pipeline.
    typedef struct packed {
        logic              data_valid;
        status_t           status;
        chan_t             channel;
        logic [FILL_W-1:0] fill;
        logic              dropped;
    } result_t;

endpackage

// File: hw/rtl/cfdb_if.sv
// Valid/ready channel interfaces of the channel frame demux buffer.
// Depends on cfdb_pkg for field widths.
interface cfdb_req_if;
    logic                         valid;
    logic                         ready;
    logic                         opcode;
    logic [cfdb_pkg::BYTE_W-1:0]  rx_byte;
    logic [cfdb_pkg::CH_W-1:0]    pop_channel;

    modport source (output valid, opcode, rx_byte, pop_channel, input ready);
    modport sink   (input valid, opcode, rx_byte, pop_channel, output ready);
endinterface

interface cfdb_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [cfdb_pkg::BYTE_W-1:0]  data_byte;
    logic                         data_valid;
    logic [2:0]                   status;
    logic [cfdb_pkg::CH_W-1:0]    frame_channel;
    logic [cfdb_pkg::FILL_W-1:0]  fill_count;
    logic                         dropped;

    modport source (output valid, data_byte, data_valid, status, frame_channel,
                    fill_count, dropped, input ready);
    modport sink   (input valid, data_byte, data_valid, status, frame_channel,
                    fill_count, dropped, output ready);
endinterface

// File: hw/rtl/cfdb_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module cfdb_ram #(
    parameter int DEPTH = 768,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/channel_frame_demux_buffer.sv
// Top level of the channel frame demux buffer: frame tracking, ring pointers and
// the output pipeline. Depends on cfdb_pkg, cfdb_if.sv and cfdb_ram.
//
//   Channel   Role      Beat content
//   req       sink      opcode, rx_byte, pop_channel
//   rsp       source    data_byte, data_valid, status, frame_channel, fill_count, dropped
//   cfg_*     write     cfg_index selects the register, cfg_wdata is its new value
//
// One beat is accepted every cycle while the output side keeps up; each beat gives
// exactly one result beat via the read and output stages. The rate is set by the
// store RAM, which takes one write or one read per beat. Reset clears the frame
// state, all ring pointers and fill levels and restores the channel codes; the
// store contents are not cleared and need no sweep. When rsp stalls, a result and
// one more in flight are held, and req.ready drops only when both are occupied.
module channel_frame_demux_buffer (
    input  logic                                clk,
    input  logic                                rst_n,
    cfdb_req_if.sink                            req,
    cfdb_rsp_if.source                          rsp,
    input  logic                                cfg_we,
    input  logic [cfdb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cfdb_pkg::BYTE_W-1:0]         cfg_wdata
);

    localparam logic [cfdb_pkg::HEAD_W-1:0] HEAD_LAST =
        cfdb_pkg::HEAD_W'(cfdb_pkg::STORE_DEPTH - 1);
    localparam logic [cfdb_pkg::FILL_W-1:0] FILL_FULL =
        cfdb_pkg::FILL_W'(cfdb_pkg::STORE_DEPTH);
    localparam logic [cfdb_pkg::SUM_W-1:0] SUM_DEPTH =
        cfdb_pkg::SUM_W'(cfdb_pkg::STORE_DEPTH);
    localparam logic [cfdb_pkg::ADDR_W-1:0] ADDR_STRIDE =
        cfdb_pkg::ADDR_W'(cfdb_pkg::STORE_DEPTH);

    // Channel codes, written from the configuration port.
    logic [cfdb_pkg::BYTE_W-1:0] delim_reg;
    logic [cfdb_pkg::BYTE_W-1:0] at_code_reg;
    logic [cfdb_pkg::BYTE_W-1:0] debug_code_reg;
    logic [cfdb_pkg::BYTE_W-1:0] setup_code_reg;

    // Frame state and per-channel ring pointers.
    logic                        in_frame_reg, in_frame_next;
    logic [cfdb_pkg::BYTE_W-1:0] open_code_reg, open_code_next;
    logic [cfdb_pkg::HEAD_W-1:0] head_reg [cfdb_pkg::CHANNELS];
    logic [cfdb_pkg::HEAD_W-1:0] head_next [cfdb_pkg::CHANNELS];
    logic [cfdb_pkg::FILL_W-1:0] fill_reg [cfdb_pkg::CHANNELS];
    logic [cfdb_pkg::FILL_W-1:0] fill_next [cfdb_pkg::CHANNELS];

    // Output pipeline: the RAM read stage, then the output register.
    logic                        s1_valid_reg;
    cfdb_pkg::result_t           s1_res_reg;
    cfdb_pkg::result_t           res_next;
    logic                        out_valid_reg;
    cfdb_pkg::result_t           out_res_reg;
    logic [cfdb_pkg::BYTE_W-1:0] out_data_reg;

    // Store RAM access.
    logic                        ram_we;
    logic [cfdb_pkg::ADDR_W-1:0] ram_waddr;
    logic                        ram_re;
    logic [cfdb_pkg::ADDR_W-1:0] ram_raddr;
    logic [cfdb_pkg::BYTE_W-1:0] ram_rdata;

    logic accept;
    logic out_free;
    logic s1_move;

    // First match wins; a code of zero never names a channel.
    function automatic cfdb_pkg::chan_t match_code(
        input logic [cfdb_pkg::BYTE_W-1:0] code,
        input logic [cfdb_pkg::BYTE_W-1:0] at_c,
        input logic [cfdb_pkg::BYTE_W-1:0] dbg_c,
        input logic [cfdb_pkg::BYTE_W-1:0] set_c
    );
        cfdb_pkg::chan_t ch;
        if (code == '0)
        begin
            ch = cfdb_pkg::CH_NONE;
        end
        else if (code == at_c)
        begin
            ch = cfdb_pkg::CH_AT;
        end
        else if (code == dbg_c)
        begin
            ch = cfdb_pkg::CH_DEBUG;
        end
        else if (code == set_c)
        begin
            ch = cfdb_pkg::CH_SETUP;
        end
        else
        begin
            ch = cfdb_pkg::CH_NONE;
        end
        return ch;
    endfunction

    // A new beat may enter when the read stage is empty or will pass its result on.
    assign out_free = !out_valid_reg || rsp.ready;
    assign s1_move  = s1_valid_reg && out_free;
    assign req.ready = !s1_valid_reg || out_free;
    assign accept   = req.valid && req.ready;

    // Configuration writes; send these only while idle; the block does not check.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg      <= cfdb_pkg::DELIM_RESET;
            at_code_reg    <= cfdb_pkg::AT_RESET;
            debug_code_reg <= cfdb_pkg::DEBUG_RESET;
            setup_code_reg <= cfdb_pkg::SETUP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfdb_pkg::cfg_idx_t'(cfg_index))
                cfdb_pkg::CFG_DELIM: delim_reg      <= cfg_wdata;
                cfdb_pkg::CFG_AT:    at_code_reg    <= cfg_wdata;
                cfdb_pkg::CFG_DEBUG: debug_code_reg <= cfg_wdata;
                cfdb_pkg::CFG_SETUP: setup_code_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Decode of one accepted beat: frame state, pointer updates, RAM access and
    // the result record. The byte write lands in the RAM at the accept edge, so a
    // later pop of the same entry always sees it; a beat is either a write or a
    // read, never both, so no forwarding is needed.
    always_comb
    begin
        cfdb_pkg::chan_t             rx_ch;
        cfdb_pkg::chan_t             open_ch;
        cfdb_pkg::chan_t             touched;
        logic [cfdb_pkg::CH_W-1:0]   pc;
        logic [cfdb_pkg::HEAD_W-1:0] head_base;
        logic [cfdb_pkg::FILL_W-1:0] fill_base;
        logic [cfdb_pkg::SUM_W-1:0]  pos_sum;
        logic [cfdb_pkg::HEAD_W-1:0] pos;
        logic [cfdb_pkg::HEAD_W-1:0] pop_head;

        rx_ch     = match_code(req.rx_byte, at_code_reg, debug_code_reg, setup_code_reg);
        open_ch   = match_code(open_code_reg, at_code_reg, debug_code_reg, setup_code_reg);
        pc        = req.pop_channel;
        touched   = cfdb_pkg::CH_NONE;
        head_base = '0;
        fill_base = '0;
        pos_sum   = '0;
        pos       = '0;
        pop_head  = '0;

        in_frame_next  = in_frame_reg;
        open_code_next = open_code_reg;
        for (int c = 0; c < cfdb_pkg::CHANNELS; c++)
        begin
            head_next[c] = head_reg[c];
            fill_next[c] = fill_reg[c];
        end

        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_re    = 1'b0;
        ram_raddr = '0;

        res_next            = '0;
        res_next.status     = cfdb_pkg::ST_SKIP;
        res_next.channel    = cfdb_pkg::CH_NONE;

        unique case (cfdb_pkg::op_t'(req.opcode))
            cfdb_pkg::OP_RX:
            begin
                if (!in_frame_reg)
                begin
                    if (req.rx_byte == delim_reg)
                    begin
                        res_next.status = cfdb_pkg::ST_SKIP;
                    end
                    else
                    begin
                        in_frame_next   = 1'b1;
                        open_code_next  = req.rx_byte;
                        touched         = rx_ch;
                        res_next.status = cfdb_pkg::ST_OPEN;
                    end
                end
                else if (req.rx_byte == delim_reg)
                begin
                    in_frame_next   = 1'b0;
                    open_code_next  = '0;
                    touched         = open_ch;
                    res_next.status = cfdb_pkg::ST_CLOSE;
                end
                else if (open_ch != cfdb_pkg::CH_NONE)
                begin
                    head_base = head_reg[open_ch];
                    fill_base = fill_reg[open_ch];
                    // A full store is emptied and the byte becomes its first entry.
                    if (fill_base == FILL_FULL)
                    begin
                        head_base        = '0;
                        fill_base        = '0;
                        res_next.dropped = 1'b1;
                    end
                    pos_sum = cfdb_pkg::SUM_W'(head_base) + cfdb_pkg::SUM_W'(fill_base);
                    if (pos_sum >= SUM_DEPTH)
                    begin
                        pos_sum = pos_sum - SUM_DEPTH;
                    end
                    pos = pos_sum[cfdb_pkg::HEAD_W-1:0];
                    ram_we    = accept;
                    ram_waddr = cfdb_pkg::ADDR_W'(open_ch) * ADDR_STRIDE
                              + cfdb_pkg::ADDR_W'(pos);
                    head_next[open_ch] = head_base;
                    fill_next[open_ch] = fill_base + 1'b1;
                    touched            = open_ch;
                    res_next.status    = cfdb_pkg::ST_STORED;
                end
                else
                begin
                    res_next.status = cfdb_pkg::ST_DISCARD;
                end
            end
            cfdb_pkg::OP_POP:
            begin
                touched = cfdb_pkg::chan_t'(pc);
                if (touched != cfdb_pkg::CH_NONE && fill_reg[pc] != '0)
                begin
                    pop_head  = head_reg[pc];
                    ram_re    = accept;
                    ram_raddr = cfdb_pkg::ADDR_W'(pc) * ADDR_STRIDE
                              + cfdb_pkg::ADDR_W'(pop_head);
                    head_next[pc] = (pop_head == HEAD_LAST) ? '0 : pop_head + 1'b1;
                    fill_next[pc] = fill_reg[pc] - 1'b1;
                    res_next.data_valid = 1'b1;
                    res_next.status     = cfdb_pkg::ST_POPPED;
                end
                else
                begin
                    res_next.status = cfdb_pkg::ST_EMPTY;
                end
            end
            default: ;
        endcase

        // The fill count reported is that of the touched store after this beat.
        res_next.channel = touched;
        if (touched != cfdb_pkg::CH_NONE)
        begin
            res_next.fill = fill_next[touched];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg  <= 1'b0;
            open_code_reg <= '0;
            for (int c = 0; c < cfdb_pkg::CHANNELS; c++)
            begin
                head_reg[c] <= '0;
                fill_reg[c] <= '0;
            end
        end
        else if (accept)
        begin
            in_frame_reg  <= in_frame_next;
            open_code_reg <= open_code_next;
            for (int c = 0; c < cfdb_pkg::CHANNELS; c++)
            begin
                head_reg[c] <= head_next[c];
                fill_reg[c] <= fill_next[c];
            end
        end
    end

    cfdb_ram #(
        .DEPTH (cfdb_pkg::MEM_DEPTH),
        .WIDTH (cfdb_pkg::BYTE_W)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (req.rx_byte),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Read stage: the RAM data for a pop appears while the record sits here.
    // The RAM output holds because it is only read again on a new accept.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_res_reg <= res_next;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_res_reg  <= s1_res_reg;
            out_data_reg <= s1_res_reg.data_valid ? ram_rdata : '0;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.data_byte     = out_data_reg;
    assign rsp.data_valid    = out_res_reg.data_valid;
    assign rsp.status        = out_res_reg.status;
    assign rsp.frame_channel = out_res_reg.channel;
    assign rsp.fill_count    = out_res_reg.fill;
    assign rsp.dropped       = out_res_reg.dropped;

endmodule

// File: hw/rtl/cfdb_checker.sv
// Port-level checker of the channel frame demux buffer, bound to the top level.
// Depends on cfdb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cfdb_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic [cfdb_pkg::BYTE_W-1:0]  rsp_data_byte,
    input logic                         rsp_data_valid,
    input logic [2:0]                   rsp_status,
    input logic [cfdb_pkg::CH_W-1:0]    rsp_frame_channel,
    input logic [cfdb_pkg::FILL_W-1:0]  rsp_fill_count,
    input logic                         rsp_dropped
);

    // A stalled result stays and keeps its byte.
    `CFDB_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data_byte))

    // Popped data is flagged exactly on a successful pop, and is zero otherwise.
    `CFDB_ASSERT_IMP(a_pop_flag, rsp_valid, rsp_data_valid == (rsp_status == cfdb_pkg::ST_POPPED))
    `CFDB_ASSERT_IMP(a_zero_data, rsp_valid && !rsp_data_valid, rsp_data_byte == '0)

    // No channel means no fill count.
    `CFDB_ASSERT_IMP(a_none_fill, rsp_valid && rsp_frame_channel == cfdb_pkg::CH_NONE, rsp_fill_count == '0)

    // A drop only happens when storing, and leaves exactly the new byte.
    `CFDB_ASSERT_IMP(a_drop_store, rsp_valid && rsp_dropped, rsp_status == cfdb_pkg::ST_STORED && rsp_fill_count == cfdb_pkg::FILL_W'(1))

endmodule

bind channel_frame_demux_buffer cfdb_checker u_cfdb_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_data_byte     (rsp.data_byte),
    .rsp_data_valid    (rsp.data_valid),
    .rsp_status        (rsp.status),
    .rsp_frame_channel (rsp.frame_channel),
    .rsp_fill_count    (rsp.fill_count),
    .rsp_dropped       (rsp.dropped)
);

// File: test/tb_channel_frame_demux_buffer.sv
// Self-checking testbench of channel_frame_demux_buffer: framed byte routing and pops.
// Depends on cfdb_pkg, cfdb_if.sv and the block itself; a built-in predictor checks
// every result beat against the expected outcome of the matching request beat.
module tb_channel_frame_demux_buffer;

    import cfdb_pkg::*;

    localparam int HALF_PERIOD = 4;
    // Cycles without any beat moving before the run is declared hung.
    localparam int QUIET_LIMIT = 2000;
    // Cycles to let the two-stage output pipeline settle after the last result.
    localparam int SETTLE = 6;

    // One result beat as the testbench sees it.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              valid;
        status_t           status;
        chan_t             chan;
        logic [FILL_W-1:0] fill;
        logic              dropped;
    } outcome_t;

    // One request beat; rows of the directed table may carry a fixed outcome.
    typedef struct {
        op_t               op;
        logic [BYTE_W-1:0] rx;
        logic [CH_W-1:0]   pc;
        bit                fixed;
        outcome_t          want;
    } stim_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [BYTE_W-1:0] cfg_wdata;

    cfdb_req_if req_bus ();
    cfdb_rsp_if rsp_bus ();

    channel_frame_demux_buffer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_bus),
        .rsp       (rsp_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #HALF_PERIOD;
        clk = 1'b1;
        #HALF_PERIOD;
    end

    // Predictor state: the channel codes, the frame tracker and the three rings.
    logic [BYTE_W-1:0] delim_code;
    logic [BYTE_W-1:0] at_code;
    logic [BYTE_W-1:0] debug_code;
    logic [BYTE_W-1:0] setup_code;
    logic              in_frame;
    logic [BYTE_W-1:0] open_code;
    logic [BYTE_W-1:0] ring [CHANNELS][STORE_DEPTH];
    logic [HEAD_W-1:0] ring_head [CHANNELS];
    logic [FILL_W-1:0] ring_fill [CHANNELS];

    outcome_t demux_results_due[$];
    stim_t    directed_rows[$];
    stim_t    cur_item;

    int mismatches;
    int beats_in;
    int results_checked;
    int overflows;
    int settings_used;
    int burst_left;
    int quiet_cycles;
    int status_seen[8];

    // A code byte of zero never selects a channel; otherwise the first match wins.
    function automatic chan_t lookup_channel(input logic [BYTE_W-1:0] code);
        if (code == '0)
            return CH_NONE;
        if (code == at_code)
            return CH_AT;
        if (code == debug_code)
            return CH_DEBUG;
        if (code == setup_code)
            return CH_SETUP;
        return CH_NONE;
    endfunction

    // Applies one request beat to the predictor state and returns its result beat.
    function automatic outcome_t demux_outcome(input op_t op, input logic [BYTE_W-1:0] b,
                                               input logic [CH_W-1:0] pc);
        outcome_t r;
        chan_t ch;
        int idx;
        logic [HEAD_W-1:0] slot;
        r = '0;
        r.status = ST_SKIP;
        r.chan = CH_NONE;
        if (op == OP_RX)
        begin
            if (!in_frame)
            begin
                if (b != delim_code)
                begin
                    in_frame = 1'b1;
                    open_code = b;
                    r.chan = lookup_channel(b);
                    r.status = ST_OPEN;
                end
            end
            else
            begin
                ch = lookup_channel(open_code);
                r.chan = ch;
                if (b == delim_code)
                begin
                    in_frame = 1'b0;
                    open_code = '0;
                    r.status = ST_CLOSE;
                end
                else if (ch != CH_NONE)
                begin
                    idx = int'(ch);
                    // A byte that meets a full ring throws the old contents away first.
                    if (ring_fill[idx] == STORE_DEPTH)
                    begin
                        ring_fill[idx] = '0;
                        ring_head[idx] = '0;
                        r.dropped = 1'b1;
                    end
                    slot = ring_head[idx] + ring_fill[idx][HEAD_W-1:0];
                    ring[idx][slot] = b;
                    ring_fill[idx] = ring_fill[idx] + 1'b1;
                    r.status = ST_STORED;
                end
                else
                begin
                    r.status = ST_DISCARD;
                end
            end
        end
        else if (pc != CH_NONE && ring_fill[pc] != '0)
        begin
            r.chan = chan_t'(pc);
            r.data = ring[pc][ring_head[pc]];
            r.valid = 1'b1;
            ring_head[pc] = ring_head[pc] + 1'b1;
            ring_fill[pc] = ring_fill[pc] - 1'b1;
            r.status = ST_POPPED;
        end
        else
        begin
            // An empty ring and the nonexistent fourth channel answer the same way.
            r.chan = chan_t'(pc);
            r.status = ST_EMPTY;
        end
        r.fill = (r.chan == CH_NONE) ? '0 : ring_fill[r.chan];
        return r;
    endfunction

    function automatic stim_t mk(input op_t op, input logic [BYTE_W-1:0] b,
                                 input logic [CH_W-1:0] pc, input bit fixed,
                                 input status_t st, input chan_t ch, input int fill,
                                 input logic [BYTE_W-1:0] data);
        stim_t s;
        s.op = op;
        s.rx = b;
        s.pc = pc;
        s.fixed = fixed;
        s.want = '0;
        s.want.data = data;
        s.want.valid = (st == ST_POPPED);
        s.want.status = st;
        s.want.chan = ch;
        s.want.fill = FILL_W'(fill);
        return s;
    endfunction

    // Receive beat; the unused channel field still gets random bits.
    function automatic stim_t rx_item(input logic [BYTE_W-1:0] b);
        return mk(OP_RX, b, CH_W'($urandom), 1'b0, ST_SKIP, CH_NONE, 0, '0);
    endfunction

    // Pop beat, now and then aimed at the channel that does not exist.
    function automatic stim_t pop_item();
        logic [CH_W-1:0] pc;
        pc = ($urandom_range(0, 7) == 0) ? CH_NONE : CH_W'($urandom_range(0, 2));
        return mk(OP_POP, BYTE_W'($urandom), pc, 1'b0, ST_SKIP, CH_NONE, 0, '0);
    endfunction

    // Any byte but the delimiter, so that a frame stays open.
    function automatic logic [BYTE_W-1:0] payload_byte();
        logic [BYTE_W-1:0] b;
        b = BYTE_W'($urandom);
        while (b == delim_code)
            b = BYTE_W'($urandom);
        return b;
    endfunction

    // Sends one beat. The sender runs in bursts; between bursts valid drops for a
    // random gap, and some bursts follow one another with no gap at all.
    task automatic push_item(input stim_t s);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 60);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                req_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_bus.valid <= 1'b1;
        req_bus.opcode <= s.op;
        req_bus.rx_byte <= s.rx;
        req_bus.pop_channel <= s.pc;
        cur_item <= s;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
    endtask

    // Holds the sender off until every result is back and the pipeline is empty.
    task automatic wait_drained();
        req_bus.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (demux_results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Writes all four code registers back to back; only called while idle.
    task automatic load_codes(input logic [BYTE_W-1:0] delim, input logic [BYTE_W-1:0] at,
                              input logic [BYTE_W-1:0] dbg, input logic [BYTE_W-1:0] setup);
        cfg_idx_t order[4];
        logic [BYTE_W-1:0] vals[4];
        order = '{CFG_DELIM, CFG_AT, CFG_DEBUG, CFG_SETUP};
        vals = '{delim, at, dbg, setup};
        for (int i = 0; i < 4; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= order[i];
            cfg_wdata <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        delim_code = delim;
        at_code = at;
        debug_code = dbg;
        setup_code = setup;
        settings_used++;
    endtask

    // Mostly well-formed frames with random content, mixed with pops, stray bytes
    // and frames that never get their closing delimiter. In flood mode the frames
    // are long and aimed mostly at the AT ring, so that it overflows.
    task automatic random_traffic(input int n_items, input int pop_pct, input bit flood);
        int sent;
        int roll;
        int len;
        logic [BYTE_W-1:0] code;
        sent = 0;
        while (sent < n_items)
        begin
            roll = $urandom_range(0, 99);
            if (roll < pop_pct)
            begin
                push_item(pop_item());
                sent++;
            end
            else if (roll < pop_pct + 8)
            begin
                push_item(rx_item(BYTE_W'($urandom)));
                sent++;
            end
            else
            begin
                repeat ($urandom_range(1, 3))
                begin
                    push_item(rx_item(delim_code));
                    sent++;
                end
                roll = $urandom_range(0, 9);
                if (flood && roll < 8)
                    code = at_code;
                else if (roll < 7)
                    case ($urandom_range(0, 2))
                        0: code = at_code;
                        1: code = debug_code;
                        default: code = setup_code;
                    endcase
                else if (roll == 7)
                    code = '0;
                else
                    code = BYTE_W'($urandom);
                push_item(rx_item(code));
                sent++;
                len = flood ? $urandom_range(180, 300) : $urandom_range(0, 12);
                repeat (len)
                begin
                    if ($urandom_range(0, 99) < pop_pct / 2)
                    begin
                        push_item(pop_item());
                        sent++;
                    end
                    push_item(rx_item(payload_byte()));
                    sent++;
                end
                if ($urandom_range(0, 9) != 0)
                begin
                    push_item(rx_item(delim_code));
                    sent++;
                end
            end
            if ($urandom_range(0, 299) == 0)
                wait_drained();
        end
    endtask

    // Receiver: switches between always ready, short random stalls and long stalls.
    initial
    begin
        int stall_left;
        int mode;
        int mode_left;
        stall_left = 0;
        mode = 0;
        mode_left = 0;
        rsp_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(100, 600);
            end
            mode_left--;
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_bus.ready <= 1'b0;
            end
            else
            begin
                rsp_bus.ready <= 1'b1;
                if (mode == 1 && $urandom_range(0, 2) == 0)
                    stall_left = $urandom_range(1, 3);
                else if (mode == 2 && $urandom_range(0, 15) == 0)
                    stall_left = $urandom_range(5, 30);
            end
        end
    end

    // Checks each result beat against the oldest expectation, then predicts the
    // request beat of the same edge; a result is always older than that request.
    always @(posedge clk)
    begin
        outcome_t got;
        outcome_t want;
        if (rst_n)
        begin
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                got.data = rsp_bus.data_byte;
                got.valid = rsp_bus.data_valid;
                got.status = status_t'(rsp_bus.status);
                got.chan = chan_t'(rsp_bus.frame_channel);
                got.fill = rsp_bus.fill_count;
                got.dropped = rsp_bus.dropped;
                if (demux_results_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected result data=%02h vld=%0d st=%0d ch=%0d fill=%0d drop=%0d",
                                 got.data, got.valid, got.status, got.chan, got.fill,
                                 got.dropped);
                end
                else
                begin
                    want = demux_results_due.pop_front();
                    results_checked++;
                    status_seen[got.status]++;
                    if (got.dropped)
                        overflows++;
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: result %0d expected data=%02h vld=%0d st=%0d ch=%0d fill=%0d drop=%0d, got data=%02h vld=%0d st=%0d ch=%0d fill=%0d drop=%0d",
                                     results_checked, want.data, want.valid, want.status,
                                     want.chan, want.fill, want.dropped, got.data, got.valid,
                                     got.status, got.chan, got.fill, got.dropped);
                    end
                end
            end
            if (req_bus.valid && req_bus.ready)
            begin
                want = demux_outcome(op_t'(req_bus.opcode), req_bus.rx_byte,
                                     req_bus.pop_channel);
                if (cur_item.fixed)
                    want = cur_item.want;
                demux_results_due.push_back(want);
                beats_in++;
            end
        end
    end

    // Watchdog: any accepted beat on either side restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("ERROR: no beat moved for %0d cycles, %0d results outstanding",
                         QUIET_LIMIT, demux_results_due.size());
                $display("tb_channel_frame_demux_buffer failed");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        req_bus.valid <= 1'b0;
        req_bus.opcode <= OP_RX;
        req_bus.rx_byte <= '0;
        req_bus.pop_channel <= '0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_DELIM;
        cfg_wdata <= '0;
        cur_item.fixed = 1'b0;
        mismatches = 0;
        beats_in = 0;
        results_checked = 0;
        overflows = 0;
        settings_used = 1;
        burst_left = 0;
        quiet_cycles = 0;
        foreach (status_seen[i])
            status_seen[i] = 0;

        // Predictor starts from the reset state of the block.
        delim_code = DELIM_RESET;
        at_code = AT_RESET;
        debug_code = DEBUG_RESET;
        setup_code = SETUP_RESET;
        in_frame = 1'b0;
        open_code = '0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            ring_head[c] = '0;
            ring_fill[c] = '0;
        end

        // Directed table under the reset codes. Rows marked fixed carry an outcome
        // that can be read straight off the behavior; the rest go to the predictor.
        directed_rows.push_back(mk(OP_POP, 8'h00, CH_AT, 1, ST_EMPTY, CH_AT, 0, 8'h00));
        directed_rows.push_back(mk(OP_POP, 8'hFF, CH_NONE, 1, ST_EMPTY, CH_NONE, 0, 8'h00));
        directed_rows.push_back(mk(OP_RX, DELIM_RESET, CH_NONE, 1, ST_SKIP, CH_NONE, 0, 8'h00));
        directed_rows.push_back(mk(OP_RX, DELIM_RESET, CH_AT, 1, ST_SKIP, CH_NONE, 0, 8'h00));
        directed_rows.push_back(mk(OP_RX, AT_RESET, CH_AT, 1, ST_OPEN, CH_AT, 0, 8'h00));
        directed_rows.push_back(mk(OP_RX, 8'h00, CH_SETUP, 1, ST_STORED, CH_AT, 1, 8'h00));
        directed_rows.push_back(mk(OP_RX, 8'hFF, CH_DEBUG, 1, ST_STORED, CH_AT, 2, 8'h00));
        directed_rows.push_back(mk(OP_RX, DELIM_RESET, CH_AT, 1, ST_CLOSE, CH_AT, 2, 8'h00));
        directed_rows.push_back(mk(OP_RX, DEBUG_RESET, CH_AT, 0, ST_SKIP, CH_NONE, 0, 8'h00));
        directed_rows.push_back(mk(OP_RX, 8'h55, CH_NONE, 0, ST_SKIP, CH_NONE, 0, 8'h00));
        directed_rows.push_back(mk(OP_RX, DELIM_RESET, CH_AT, 0, ST_SKIP, CH_NONE, 0, 8'h00));
        directed_rows.push_back(mk(OP_RX, SETUP_RESET, CH_AT, 0, ST_SKIP, CH_NONE, 0, 8'h00));
        directed_rows.push_back(mk(OP_RX, 8'hAA, CH_AT, 0, ST_SKIP, CH_NONE, 0, 8'h00));
        directed_rows.push_back(mk(OP_RX, DELIM_RESET, CH_AT, 0, ST_SKIP, CH_NONE, 0, 8'h00));
        // A code byte of zero opens a frame that matches no channel.
        directed_rows.push_back(mk(OP_RX, 8'h00, CH_AT, 1, ST_OPEN, CH_NONE, 0, 8'h00));
        directed_rows.push_back(mk(OP_RX, 8'h33, CH_AT, 1, ST_DISCARD, CH_NONE, 0, 8'h00));
        directed_rows.push_back(mk(OP_RX, DELIM_RESET, CH_AT, 1, ST_CLOSE, CH_NONE, 0, 8'h00));
        directed_rows.push_back(mk(OP_RX, 8'h7E, CH_AT, 0, ST_SKIP, CH_NONE, 0, 8'h00));
        directed_rows.push_back(mk(OP_RX, DELIM_RESET, CH_AT, 0, ST_SKIP, CH_NONE, 0, 8'h00));
        directed_rows.push_back(mk(OP_POP, 8'h00, CH_AT, 1, ST_POPPED, CH_AT, 1, 8'h00));
        directed_rows.push_back(mk(OP_POP, 8'h00, CH_AT, 1, ST_POPPED, CH_AT, 0, 8'hFF));
        directed_rows.push_back(mk(OP_POP, 8'h00, CH_AT, 1, ST_EMPTY, CH_AT, 0, 8'h00));
        directed_rows.push_back(mk(OP_POP, 8'h00, CH_DEBUG, 0, ST_SKIP, CH_NONE, 0, 8'h00));
        directed_rows.push_back(mk(OP_POP, 8'h00, CH_SETUP, 0, ST_SKIP, CH_NONE, 0, 8'h00));
        directed_rows.push_back(mk(OP_POP, 8'h00, CH_SETUP, 0, ST_SKIP, CH_NONE, 0, 8'h00));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            push_item(directed_rows[i]);
        wait_drained();

        // Random phases, each under its own set of codes.
        random_traffic(400, 25, 1'b0);
        wait_drained();
        load_codes(8'h00, 8'hFF, 8'h01, 8'h80);
        random_traffic(300, 25, 1'b0);
        wait_drained();
        load_codes(8'hFF, 8'h01, 8'hFF, 8'h7F);
        random_traffic(300, 30, 1'b0);
        wait_drained();
        load_codes(BYTE_W'($urandom), BYTE_W'($urandom_range(1, 255)),
                   BYTE_W'($urandom_range(1, 255)), BYTE_W'($urandom_range(1, 255)));
        random_traffic(800, 3, 1'b1);
        wait_drained();
        // The AT and debug codes the same, and the setup code equal to the delimiter.
        load_codes(8'h55, 8'h40, 8'h40, 8'h55);
        random_traffic(250, 20, 1'b0);
        wait_drained();

        $display("Run covered %0d request beats under %0d code settings, %0d results checked, %0d ring overflows.",
                 beats_in, settings_used, results_checked, overflows);
        $display("Results by kind: skip %0d, open %0d, stored %0d, discard %0d, close %0d, popped %0d, empty %0d.",
                 status_seen[ST_SKIP], status_seen[ST_OPEN], status_seen[ST_STORED],
                 status_seen[ST_DISCARD], status_seen[ST_CLOSE], status_seen[ST_POPPED],
                 status_seen[ST_EMPTY]);
        if (mismatches == 0 && demux_results_due.size() == 0)
            $display("tb_channel_frame_demux_buffer passed");
        else
            $display("tb_channel_frame_demux_buffer failed");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/cfdb_pkg.sv
hw/rtl/cfdb_if.sv
hw/rtl/cfdb_ram.sv
hw/rtl/channel_frame_demux_buffer.sv
hw/rtl/cfdb_checker.sv
test/tb_channel_frame_demux_buffer.sv
